[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the SWD host engine.
// No dependencies; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define SWD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Short form for modules clocked by clk_i with reset rst_ni.
`define SWD_ASSERT_I(lbl, prop, msg) \
  `SWD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/swd_pkg.sv]
// Shared types and constants of the SWD host transfer engine.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package swd_pkg;

  // Request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Transfer status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_WAIT_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_FAULT        = 3'd2;
  localparam logic [2:0] ST_BAD_ACK      = 3'd3;
  localparam logic [2:0] ST_PARITY_ERR   = 3'd4;

  // Acknowledge codes as received, LSB first
  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  // Sequencer phases
  localparam int unsigned PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_HDR       = 4'd1;
  localparam logic [PHASE_W-1:0] PH_TRN_ACK   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ACK       = 4'd3;
  localparam logic [PHASE_W-1:0] PH_TRN_WDATA = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WDATA     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WPAR      = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WIDLE     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RDATA     = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RPAR      = 4'd9;
  localparam logic [PHASE_W-1:0] PH_TRN_RIDLE = 4'd10;
  localparam logic [PHASE_W-1:0] PH_RIDLE     = 4'd11;
  localparam logic [PHASE_W-1:0] PH_TRN_FAIL  = 4'd12;
  localparam logic [PHASE_W-1:0] PH_FAIL      = 4'd13;
  localparam logic [PHASE_W-1:0] PH_TRN_HDR   = 4'd14;

  // Frame lengths
  localparam int unsigned HDR_BITS  = 8;
  localparam int unsigned ACK_BITS  = 3;
  localparam int unsigned DATA_BITS = 32;

  // Configuration space
  localparam int unsigned     PADDR_W         = 3;
  localparam logic [2:0]      REG_RETRY_LIMIT = 3'd0;
  localparam logic [7:0]      RETRY_LIMIT_RST = 8'd100;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        ap_select;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_sample;
  } swd_in_t;

  typedef struct packed {
    logic        clock_active;
    logic        swdio_drive;
    logic        swdio_enable;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
  } swd_out_t;

  typedef struct packed {
    logic [7:0] retry_limit;
  } swd_cfg_t;

endpackage

[rtl/swd_cfg_regs.sv]
// APB-style configuration registers of the SWD host engine.
// Depends on swd_pkg for the address map and the configuration struct.
`timescale 1ns / 1ps

module swd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output swd_pkg::swd_cfg_t           cfg_o
);
  import swd_pkg::*;

  logic [7:0] retry_limit_q, retry_limit_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_RETRY_LIMIT);

  always_comb begin
    retry_limit_d = retry_limit_q;
    if (wr_en) begin
      retry_limit_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_LIMIT_RST;
    end else begin
      retry_limit_q <= retry_limit_d;
    end
  end

  assign prdata = (paddr == REG_RETRY_LIMIT) ? {24'd0, retry_limit_q} : 32'd0;
  assign cfg_o.retry_limit = retry_limit_q;

endmodule

[rtl/swd_engine.sv]
// SWD transfer sequencer: phase state and one-period update per request.
// Depends on swd_pkg for phase codes, opcodes, status codes and payload types.
`timescale 1ns / 1ps

module swd_engine #(
  parameter int unsigned FAIL_RESET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  swd_pkg::swd_in_t   item_i,
  input  swd_pkg::swd_cfg_t  cfg_i,
  output swd_pkg::swd_out_t  res_o
);
  import swd_pkg::*;

  localparam int unsigned MaxBits = (FAIL_RESET_BITS > DATA_BITS) ? FAIL_RESET_BITS : DATA_BITS;
  localparam int unsigned CntW    = $clog2(MaxBits + 1);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CntW-1:0]    bit_count_q, bit_count_d;
  logic [31:0]        shift_word_q, shift_word_d;
  logic [7:0]         header_q, header_d;
  logic               line_driven_q, line_driven_d;
  logic [7:0]         retries_q, retries_d;
  logic [2:0]         ack_q, ack_d;
  logic               parity_q, parity_d;
  logic [2:0]         pending_q, pending_d;

  // Phase that follows a turnaround period
  function automatic logic [PHASE_W-1:0] trn_next(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] nxt;
    case (ph)
      PH_TRN_HDR:   nxt = PH_HDR;
      PH_TRN_ACK:   nxt = PH_ACK;
      PH_TRN_WDATA: nxt = PH_WDATA;
      PH_TRN_RIDLE: nxt = PH_RIDLE;
      default:      nxt = PH_FAIL;
    endcase
    return nxt;
  endfunction

  always_comb begin
    logic [CntW-1:0] cnt_inc;
    logic [2:0]      ack_new;
    logic            rnw;
    logic            hpar;

    phase_d       = phase_q;
    bit_count_d   = bit_count_q;
    shift_word_d  = shift_word_q;
    header_d      = header_q;
    line_driven_d = line_driven_q;
    retries_d     = retries_q;
    ack_d         = ack_q;
    parity_d      = parity_q;
    pending_d     = pending_q;

    cnt_inc = bit_count_q + CntW'(1);
    ack_new = ack_q | (3'(item_i.swdio_sample) << bit_count_q[1:0]);
    rnw     = (item_i.opcode == OP_READ);
    hpar    = item_i.ap_select ^ rnw ^ item_i.reg_addr[0] ^ item_i.reg_addr[1];

    res_o              = '0;
    res_o.swdio_enable = line_driven_q;
    res_o.status       = ST_OK;

    if (step_i) begin
      if (item_i.opcode == OP_READ || item_i.opcode == OP_WRITE) begin
        // A start while busy is dropped
        if (phase_q == PH_IDLE) begin
          header_d     = {1'b1, 1'b0, hpar, item_i.reg_addr[1], item_i.reg_addr[0],
                          rnw, item_i.ap_select, 1'b1};
          shift_word_d = rnw ? 32'd0 : item_i.write_data;
          pending_d    = ST_OK;
          if (cfg_i.retry_limit == 8'd0) begin
            retries_d      = 8'd0;
            res_o.done_res = 1'b1;
            res_o.status   = ST_WAIT_TIMEOUT;
          end else begin
            retries_d   = cfg_i.retry_limit - 8'd1;
            bit_count_d = '0;
            parity_d    = 1'b0;
            ack_d       = 3'd0;
            phase_d     = line_driven_q ? PH_HDR : PH_TRN_HDR;
          end
        end
      end else if (phase_q != PH_IDLE) begin
        res_o.clock_active = 1'b1;
        unique case (phase_q) inside
          PH_TRN_HDR, PH_TRN_ACK, PH_TRN_WDATA, PH_TRN_RIDLE, PH_TRN_FAIL: begin
            res_o.swdio_drive  = 1'b1;
            res_o.swdio_enable = 1'b0;
            phase_d            = trn_next(phase_q);
            bit_count_d        = '0;
            // Line stays released only when the target answers next
            line_driven_d      = (phase_q != PH_TRN_ACK);
          end
          PH_HDR: begin
            res_o.swdio_enable = 1'b1;
            line_driven_d      = 1'b1;
            res_o.swdio_drive  = header_q[bit_count_q[2:0]];
            bit_count_d        = cnt_inc;
            if (cnt_inc >= CntW'(HDR_BITS)) begin
              bit_count_d = '0;
              ack_d       = 3'd0;
              phase_d     = PH_TRN_ACK;
            end
          end
          PH_ACK: begin
            res_o.swdio_enable = 1'b0;
            ack_d              = ack_new;
            bit_count_d        = cnt_inc;
            if (cnt_inc >= CntW'(ACK_BITS)) begin
              bit_count_d = '0;
              parity_d    = 1'b0;
              if (ack_new == ACK_OK) begin
                phase_d = header_q[2] ? PH_RDATA : PH_TRN_WDATA;
              end else begin
                case (ack_new)
                  ACK_WAIT:  pending_d = ST_WAIT_TIMEOUT;
                  ACK_FAULT: pending_d = ST_FAULT;
                  default:   pending_d = ST_BAD_ACK;
                endcase
                phase_d = PH_TRN_FAIL;
              end
            end
          end
          PH_WDATA: begin
            res_o.swdio_enable = 1'b1;
            line_driven_d      = 1'b1;
            res_o.swdio_drive  = shift_word_q[bit_count_q[4:0]];
            bit_count_d        = cnt_inc;
            if (cnt_inc >= CntW'(DATA_BITS)) begin
              bit_count_d = '0;
              phase_d     = PH_WPAR;
            end
          end
          PH_WPAR: begin
            res_o.swdio_enable = 1'b1;
            line_driven_d      = 1'b1;
            res_o.swdio_drive  = ^shift_word_q;
            phase_d            = PH_WIDLE;
          end
          PH_WIDLE, PH_RIDLE: begin
            res_o.swdio_enable = 1'b1;
            line_driven_d      = 1'b1;
            res_o.done_res     = 1'b1;
            res_o.status       = ST_OK;
            if (phase_q == PH_RIDLE) begin
              res_o.read_data = shift_word_q;
            end
            phase_d = PH_IDLE;
          end
          PH_RDATA: begin
            res_o.swdio_enable = 1'b0;
            shift_word_d       = shift_word_q | (32'(item_i.swdio_sample) << bit_count_q[4:0]);
            parity_d           = parity_q ^ item_i.swdio_sample;
            bit_count_d        = cnt_inc;
            if (cnt_inc >= CntW'(DATA_BITS)) begin
              bit_count_d = '0;
              phase_d     = PH_RPAR;
            end
          end
          PH_RPAR: begin
            res_o.swdio_enable = 1'b0;
            if ((item_i.swdio_sample ^ parity_q) == 1'b0) begin
              phase_d = PH_TRN_RIDLE;
            end else begin
              pending_d = ST_PARITY_ERR;
              phase_d   = PH_TRN_FAIL;
            end
          end
          PH_FAIL: begin
            res_o.swdio_enable = 1'b1;
            line_driven_d      = 1'b1;
            bit_count_d        = cnt_inc;
            if (cnt_inc >= CntW'(FAIL_RESET_BITS)) begin
              bit_count_d = '0;
              if (pending_q == ST_WAIT_TIMEOUT && retries_q != 8'd0) begin
                // Retry: line is driven now, so the header follows directly
                retries_d = retries_q - 8'd1;
                parity_d  = 1'b0;
                ack_d     = 3'd0;
                phase_d   = PH_HDR;
              end else begin
                res_o.done_res = 1'b1;
                res_o.status   = pending_q;
                phase_d        = PH_IDLE;
              end
            end
          end
          default: begin
            res_o.clock_active = 1'b0;
            phase_d            = PH_IDLE;
          end
        endcase
      end
      res_o.busy_res = (phase_d != PH_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_count_q   <= '0;
      shift_word_q  <= 32'd0;
      header_q      <= 8'd0;
      line_driven_q <= 1'b0;
      retries_q     <= 8'd0;
      ack_q         <= 3'd0;
      parity_q      <= 1'b0;
      pending_q     <= ST_OK;
    end else if (step_i) begin
      phase_q       <= phase_d;
      bit_count_q   <= bit_count_d;
      shift_word_q  <= shift_word_d;
      header_q      <= header_d;
      line_driven_q <= line_driven_d;
      retries_q     <= retries_d;
      ack_q         <= ack_d;
      parity_q      <= parity_d;
      pending_q     <= pending_d;
    end
  end

endmodule

[rtl/swd_host_transfer_engine_unit.sv]
// SWD host transfer engine: a request passes the input register, then the result register.
// Throughput: one request per cycle while out_stall_i does not hold the result, set by
// the single-period update in swd_engine between the input and result registers; the
// output stage lets a new request in while a finished result still waits to be taken.
// Reset (rst_ni low, asynchronous): both stages empty, sequencer idle, SWDIO released,
// retry_limit back to 100. Depends on swd_pkg, swd_cfg_regs and swd_engine.
`timescale 1ns / 1ps

module swd_host_transfer_engine_unit #(
  parameter int unsigned FAIL_RESET_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swd_pkg::swd_in_t            in_data_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swd_pkg::swd_out_t           out_data_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import swd_pkg::*;

  swd_cfg_t cfg;

  logic     in_valid_q, in_valid_d;
  swd_in_t  in_item_q;
  logic     out_valid_q, out_valid_d;
  swd_out_t out_item_q;
  swd_out_t res;

  logic     out_free;  // result slot empty or being taken this cycle
  logic     in_load;   // input register may take a new request
  logic     step;      // request in the input register is processed now

  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = in_valid_q && out_free;
  assign in_load  = !in_valid_q || out_free;

  // Hold the requester off only when the input register is full and cannot drain
  assign in_stall_o = !in_load;

  swd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // One SWDCLK period (or a start) per processed request
  swd_engine #(
    .FAIL_RESET_BITS (FAIL_RESET_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d  = in_load  ? in_valid_i : in_valid_q;
    out_valid_d = out_free ? in_valid_q : out_valid_q;
  end

  // Control flags: reset clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

[rtl/swd_checker.sv]
// Port-level assertions for the SWD host transfer engine, bound to the top level.
// Depends on swd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input swd_pkg::swd_out_t out_data_o
);
  import swd_pkg::*;

  logic in_take;
  logic out_held;
  logic out_done;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_done = out_valid_o && out_data_o.done_res;

  `SWD_ASSERT_I(a_out_hold, out_held |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `SWD_ASSERT_I(a_stall_cause, in_stall_o |-> out_held, "request stalled while result side free")
  `SWD_ASSERT_I(a_result_origin, $rose(out_valid_o) |-> $past(in_take, 2), "result with no request")
  `SWD_ASSERT_I(a_done_idle, out_done |-> !out_data_o.busy_res, "done while still busy")

endmodule

bind swd_host_transfer_engine_unit swd_checker u_swd_checker (.*);
